[rtl/gspid_pkg.sv]
// gspid_pkg: shared widths, codes, reset values and payload types of the
// gain scheduled pid controller. No dependencies.
// Used by gain_scheduled_pid_three_mode.
package gspid_pkg;

	// field widths
	localparam int IN_W      = 16;	// speed inputs and drive output
	localparam int ERR_W     = IN_W + 1;	// target minus measurement
	localparam int DE_W      = ERR_W + 1;	// error difference
	localparam int GAIN_W    = 16;	// q8.8 gains
	localparam int LIM_W     = 15;	// integral and output limits
	localparam int SUM_W     = 32;	// saturating state words
	localparam int FRAC_W    = 8;	// fraction bits of the q.8 terms
	localparam int SIDE_W    = 2;
	localparam int MODE_W    = 2;

	// configuration port
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W    = REG_IDX_W + 2;
	localparam int APB_DW    = 32;

	// integration band and filter constants
	localparam int BAND_A      = 256;
	localparam int BAND_A_LOG2 = 8;
	localparam int BAND_B      = 256;
	localparam int BAND_SUM    = BAND_A + BAND_B;
	localparam int ALPHA_NUM   = 246;	// alpha = 246/256
	localparam int ALPHA_REST  = 10;	// 1 - alpha = 10/256
	localparam int ESUM_LIMIT  = 10000;

	// loop modes
	localparam logic [MODE_W-1:0] MODE_OFF = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_POS = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_INC = MODE_W'(2);
	localparam logic [MODE_W-1:0] MODE_VAR = MODE_W'(3);

	// clamp side codes
	localparam logic [SIDE_W-1:0] SIDE_NONE = SIDE_W'(0);
	localparam logic [SIDE_W-1:0] SIDE_HIGH = SIDE_W'(1);
	localparam logic [SIDE_W-1:0] SIDE_LOW  = SIDE_W'(2);

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_LOOP_MODE = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_KP_NEAR   = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_KP_FAR    = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_GAIN_SW   = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_KI        = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_KD        = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_ILIM      = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_MAX_OUT   = REG_IDX_W'(7);

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_SW_RST = GAIN_W'(1000);
	localparam logic [LIM_W-1:0]  ILIM_RST    = LIM_W'(1000);
	localparam logic [LIM_W-1:0]  MAX_OUT_RST = LIM_W'(15000);

	typedef struct packed {
		logic signed [IN_W-1:0] measured_speed;
		logic signed [IN_W-1:0] target_speed;
	} sample_t;

	typedef struct packed {
		logic signed [IN_W-1:0] drive;
		logic [SIDE_W-1:0]      clamp_side;
	} result_t;

endpackage

[rtl/gain_scheduled_pid_three_mode.sv]
// gain_scheduled_pid_three_mode: three-mode pid speed controller with a
// switched proportional gain and bit-serial gain multipliers.
// Depends on gspid_pkg.
//
// Usage:
// - sample channel (sample_valid / sample_ready / sample) takes one measured
//   and one target speed per control tick; result channel (result_valid /
//   result_ready / result) returns the clamped drive and the clamp side.
// - configuration through the apb port, register i at byte address 4*i,
//   pready is always high; write only while no item is in flight.
// - sample_ready returns once the item's result is loaded; steps: prep and
//   integ setup, a multiply phase in which the four shift-add multipliers
//   (kp, ki, kd, filter coefficient) each take one bit of the 16 bit gains
//   per step, then filter, sum and saturation, then fin loads the result.
// - the result register holds the result until it is taken; the next item
//   is taken while it waits. If the receiver stalls, the following item
//   holds in its last cycle and the loop state is not advanced until its
//   result is loaded.
// - reset restores the register defaults and clears the error history,
//   integrator, running total, filter memory and saturation side.
module gain_scheduled_pid_three_mode (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  gspid_pkg::sample_t                  sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output gspid_pkg::result_t                  result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gspid_pkg::ADDR_W-1:0]        paddr,
	input  logic [gspid_pkg::APB_DW-1:0]        pwdata,
	output logic [gspid_pkg::APB_DW-1:0]        prdata,
	output logic                                pready
);

	localparam int ERR_W   = gspid_pkg::ERR_W;
	localparam int DE_W    = gspid_pkg::DE_W;
	localparam int GAIN_W  = gspid_pkg::GAIN_W;
	localparam int SUM_W   = gspid_pkg::SUM_W;
	localparam int IN_W    = gspid_pkg::IN_W;
	localparam int FRAC_W  = gspid_pkg::FRAC_W;
	localparam int P_W     = GAIN_W + DE_W;
	localparam int I_W     = GAIN_W + SUM_W;
	localparam int DE10_W  = DE_W + 4;
	localparam int D_W     = GAIN_W + DE10_W;
	localparam int A_W     = GAIN_W + SUM_W;
	localparam int DNUM_W  = A_W + 1;
	localparam int DOUT_W  = DNUM_W - FRAC_W;
	localparam int T_W     = I_W + 3;
	localparam int WGT_W   = gspid_pkg::BAND_A_LOG2;
	localparam int BP_W    = ERR_W + WGT_W + 1;
	localparam int STEP_W  = $clog2(GAIN_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GAIN_W - 1);

	localparam logic signed [T_W-1:0] S32_MAX = T_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
	localparam logic signed [T_W-1:0] S32_MIN = ~S32_MAX;
	localparam logic signed [T_W-1:0] ES_LIM  = T_W'(gspid_pkg::ESUM_LIMIT);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_INTEG = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DOUT  = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;
	localparam logic [2:0] ST_ACC   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	function automatic logic signed [SUM_W-1:0] sat32(input logic signed [T_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[SUM_W-1:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[SUM_W-1:0];
		end else begin
			r = v[SUM_W-1:0];
		end
		return r;
	endfunction

	// configuration registers
	logic [gspid_pkg::MODE_W-1:0] loop_mode_q;
	logic [GAIN_W-1:0]            kp_near_q, kp_far_q, gain_switch_error_q;
	logic [GAIN_W-1:0]            ki_gain_q, kd_gain_q;
	logic [gspid_pkg::LIM_W-1:0]  integral_limit_q, max_output_q;

	// loop state
	logic signed [ERR_W-1:0] prev_error_q;
	logic signed [SUM_W-1:0] error_sum_q, prev_filtered_deriv_q, running_total_q;
	logic [gspid_pkg::SIDE_W-1:0] sat_side_q;

	// sequencer and working registers
	logic [2:0]              state_q;
	logic [STEP_W-1:0]       step_q;
	gspid_pkg::sample_t      smp_q;
	logic signed [ERR_W-1:0] e_q;
	logic signed [DE_W-1:0]  de_q;
	logic [IN_W-1:0]         ae_q;
	logic [GAIN_W-1:0]       kp_q;
	logic signed [SUM_W-1:0] es_next_q;
	logic [GAIN_W-1:0]       kp_sh_q, ki_sh_q, kd_sh_q, al_sh_q;
	logic signed [P_W-1:0]   mc_p_q, acc_p_q;
	logic signed [I_W-1:0]   mc_i_q, acc_i_q;
	logic signed [D_W-1:0]   mc_d_q, acc_d_q;
	logic signed [A_W-1:0]   mc_a_q, acc_a_q;
	logic signed [DOUT_W-1:0] dout_q;
	logic signed [I_W-1:0]   iout_q;
	logic signed [T_W-1:0]   t_q, acc8_q;
	logic signed [SUM_W-1:0] rt_new_q;
	logic                    result_valid_q;
	gspid_pkg::result_t      result_q;

	// combinational nets
	logic [gspid_pkg::REG_IDX_W-1:0] cfg_idx;
	logic                    cfg_wr;
	logic signed [ERR_W-1:0] e_c, neg_e_c;
	logic [IN_W-1:0]         ae_c;
	logic signed [DE_W-1:0]  de_c;
	logic [GAIN_W-1:0]       kp_c;
	logic                    hold_c;
	logic signed [T_W-1:0]   sum_e_c, sum_b_c;
	logic [IN_W:0]           wdiff_c;
	logic [WGT_W-1:0]        wgt_c;
	logic signed [BP_W-1:0]  bp_c, inc_c;
	logic signed [SUM_W-1:0] es1_c, es3_c, es_next_c;
	logic signed [DE10_W-1:0] de10_c;
	logic signed [I_W-1:0]   mc_i_c;
	logic signed [DNUM_W-1:0] dnum_c;
	logic signed [I_W-1:0]   ilim_s, iout_c;
	logic signed [I_W-1:0]   term2_c;
	logic signed [DOUT_W-1:0] term3_c;
	logic signed [T_W-1:0]   t_c, rt_sum_c;
	logic signed [SUM_W-1:0] rt_new_c, pfd_new_c;
	logic signed [T_W-1:0]   dq_c, mo_s, neg_mo_s;
	gspid_pkg::result_t      res_c;
	logic                    fire_fin;

	assign pready       = 1'b1;
	assign cfg_idx      = paddr[gspid_pkg::ADDR_W-1:2];
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign fire_fin     = (state_q == ST_FIN) && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode_q         <= gspid_pkg::MODE_POS;
			kp_near_q           <= '0;
			kp_far_q            <= '0;
			gain_switch_error_q <= gspid_pkg::GAIN_SW_RST;
			ki_gain_q           <= '0;
			kd_gain_q           <= '0;
			integral_limit_q    <= gspid_pkg::ILIM_RST;
			max_output_q        <= gspid_pkg::MAX_OUT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				gspid_pkg::REG_LOOP_MODE: loop_mode_q <= pwdata[gspid_pkg::MODE_W-1:0];
				gspid_pkg::REG_KP_NEAR:   kp_near_q <= pwdata[GAIN_W-1:0];
				gspid_pkg::REG_KP_FAR:    kp_far_q <= pwdata[GAIN_W-1:0];
				gspid_pkg::REG_GAIN_SW:   gain_switch_error_q <= pwdata[GAIN_W-1:0];
				gspid_pkg::REG_KI:        ki_gain_q <= pwdata[GAIN_W-1:0];
				gspid_pkg::REG_KD:        kd_gain_q <= pwdata[GAIN_W-1:0];
				gspid_pkg::REG_ILIM:      integral_limit_q <= pwdata[gspid_pkg::LIM_W-1:0];
				gspid_pkg::REG_MAX_OUT:   max_output_q <= pwdata[gspid_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			gspid_pkg::REG_LOOP_MODE: prdata = gspid_pkg::APB_DW'(loop_mode_q);
			gspid_pkg::REG_KP_NEAR:   prdata = gspid_pkg::APB_DW'(kp_near_q);
			gspid_pkg::REG_KP_FAR:    prdata = gspid_pkg::APB_DW'(kp_far_q);
			gspid_pkg::REG_GAIN_SW:   prdata = gspid_pkg::APB_DW'(gain_switch_error_q);
			gspid_pkg::REG_KI:        prdata = gspid_pkg::APB_DW'(ki_gain_q);
			gspid_pkg::REG_KD:        prdata = gspid_pkg::APB_DW'(kd_gain_q);
			gspid_pkg::REG_ILIM:      prdata = gspid_pkg::APB_DW'(integral_limit_q);
			gspid_pkg::REG_MAX_OUT:   prdata = gspid_pkg::APB_DW'(max_output_q);
			default:                  prdata = '0;
		endcase
	end

	// error, magnitude and gain schedule
	assign e_c     = ERR_W'(smp_q.target_speed) - ERR_W'(smp_q.measured_speed);
	assign neg_e_c = -e_c;
	assign ae_c    = e_c[ERR_W-1] ? neg_e_c[IN_W-1:0] : e_c[IN_W-1:0];
	assign de_c    = DE_W'(e_c) - DE_W'(prev_error_q);
	assign kp_c    = (ae_c > gain_switch_error_q) ? kp_far_q : kp_near_q;

	// integrator update for the positional and variable integral modes
	assign hold_c  = ((sat_side_q == gspid_pkg::SIDE_HIGH) && !e_q[ERR_W-1] && (e_q != '0))
		|| ((sat_side_q == gspid_pkg::SIDE_LOW) && e_q[ERR_W-1]);
	assign sum_e_c = T_W'(error_sum_q) + T_W'(e_q);
	assign wdiff_c = (IN_W + 1)'(gspid_pkg::BAND_SUM) - {1'b0, ae_q};
	assign wgt_c   = wdiff_c[WGT_W-1:0];
	assign bp_c    = BP_W'(e_q) * BP_W'(signed'({1'b0, wgt_c}));
	assign inc_c   = bp_c >>> gspid_pkg::BAND_A_LOG2;
	assign sum_b_c = T_W'(error_sum_q) + T_W'(inc_c);
	assign de10_c  = (DE10_W'(de_q) <<< 3) + (DE10_W'(de_q) <<< 1);

	always_comb begin
		if (sum_e_c > ES_LIM) begin
			es1_c = ES_LIM[SUM_W-1:0];
		end else if (sum_e_c < -ES_LIM) begin
			es1_c = -ES_LIM[SUM_W-1:0];
		end else begin
			es1_c = sum_e_c[SUM_W-1:0];
		end

		if (hold_c) begin
			es3_c = error_sum_q;
		end else if (ae_q <= IN_W'(gspid_pkg::BAND_B)) begin
			es3_c = sat32(sum_e_c);
		end else if (ae_q >= IN_W'(gspid_pkg::BAND_SUM)) begin
			es3_c = '0;
		end else begin
			es3_c = sat32(sum_b_c);
		end

		case (loop_mode_q)
			gspid_pkg::MODE_POS: begin
				es_next_c = es1_c;
				mc_i_c    = I_W'(error_sum_q);
			end
			gspid_pkg::MODE_INC: begin
				es_next_c = error_sum_q;
				mc_i_c    = I_W'(e_q);
			end
			gspid_pkg::MODE_VAR: begin
				es_next_c = es3_c;
				mc_i_c    = I_W'(es3_c);
			end
			default: begin
				es_next_c = error_sum_q;
				mc_i_c    = I_W'(e_q);
			end
		endcase
	end

	// filtered derivative and clamped integral term
	assign dnum_c = DNUM_W'(acc_d_q) + DNUM_W'(acc_a_q);
	assign ilim_s = I_W'({integral_limit_q, FRAC_W'(0)});
	assign iout_c = (acc_i_q > ilim_s) ? ilim_s :
		(acc_i_q < -ilim_s) ? -ilim_s : acc_i_q;

	// output sum and running total
	assign term2_c  = (loop_mode_q == gspid_pkg::MODE_VAR) ? acc_i_q : iout_q;
	assign term3_c  = (loop_mode_q == gspid_pkg::MODE_POS) ? DOUT_W'(acc_d_q) : dout_q;
	assign t_c      = T_W'(acc_p_q) + T_W'(term2_c) + T_W'(term3_c);
	assign rt_sum_c = T_W'(running_total_q) + t_q;
	assign rt_new_c = sat32(rt_sum_c);
	assign pfd_new_c = sat32(T_W'(dout_q));

	// drive clamp
	assign dq_c     = acc8_q >>> FRAC_W;
	assign mo_s     = T_W'(max_output_q);
	assign neg_mo_s = -mo_s;

	always_comb begin
		if (loop_mode_q == gspid_pkg::MODE_OFF) begin
			res_c.drive      = '0;
			res_c.clamp_side = gspid_pkg::SIDE_NONE;
		end else if (dq_c > mo_s) begin
			res_c.drive      = mo_s[IN_W-1:0];
			res_c.clamp_side = gspid_pkg::SIDE_HIGH;
		end else if (dq_c < neg_mo_s) begin
			res_c.drive      = neg_mo_s[IN_W-1:0];
			res_c.clamp_side = gspid_pkg::SIDE_LOW;
		end else begin
			res_c.drive      = dq_c[IN_W-1:0];
			res_c.clamp_side = gspid_pkg::SIDE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (sample_valid) state_q <= ST_PREP;
				ST_PREP:  state_q <= ST_INTEG;
				ST_INTEG: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) state_q <= ST_DOUT;
				end
				ST_DOUT:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_FIN;
				ST_FIN:   if (fire_fin) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (sample_valid) smp_q <= sample;
			ST_PREP: begin
				e_q  <= e_c;
				de_q <= de_c;
				ae_q <= ae_c;
				kp_q <= kp_c;
			end
			ST_INTEG: begin
				es_next_q <= es_next_c;
				kp_sh_q   <= kp_q;
				ki_sh_q   <= ki_gain_q;
				kd_sh_q   <= kd_gain_q;
				al_sh_q   <= GAIN_W'(gspid_pkg::ALPHA_NUM);
				mc_p_q    <= P_W'((loop_mode_q == gspid_pkg::MODE_INC) ? de_q : DE_W'(e_q));
				mc_i_q    <= mc_i_c;
				mc_d_q    <= (loop_mode_q == gspid_pkg::MODE_POS) ? D_W'(de_q) : D_W'(de10_c);
				mc_a_q    <= A_W'(prev_filtered_deriv_q);
				acc_p_q   <= '0;
				acc_i_q   <= '0;
				acc_d_q   <= '0;
				acc_a_q   <= '0;
			end
			ST_MUL: begin
				// one gain bit per lane per cycle, lsb first
				if (kp_sh_q[0]) acc_p_q <= acc_p_q + mc_p_q;
				if (ki_sh_q[0]) acc_i_q <= acc_i_q + mc_i_q;
				if (kd_sh_q[0]) acc_d_q <= acc_d_q + mc_d_q;
				if (al_sh_q[0]) acc_a_q <= acc_a_q + mc_a_q;
				mc_p_q  <= mc_p_q <<< 1;
				mc_i_q  <= mc_i_q <<< 1;
				mc_d_q  <= mc_d_q <<< 1;
				mc_a_q  <= mc_a_q <<< 1;
				kp_sh_q <= kp_sh_q >> 1;
				ki_sh_q <= ki_sh_q >> 1;
				kd_sh_q <= kd_sh_q >> 1;
				al_sh_q <= al_sh_q >> 1;
			end
			ST_DOUT: begin
				// floor of (10*kd*de + 246*prev) / 256; the factor 10 applies outside positional mode
				dout_q <= dnum_c[DNUM_W-1:FRAC_W];
				iout_q <= iout_c;
			end
			ST_SUM: t_q <= t_c;
			ST_ACC: begin
				rt_new_q <= rt_new_c;
				acc8_q   <= (loop_mode_q == gspid_pkg::MODE_INC) ? T_W'(rt_new_c) : t_q;
			end
			ST_FIN: if (fire_fin) result_q <= res_c;
			default: ;
		endcase
	end

	// loop state advances only when the item's result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q          <= '0;
			error_sum_q           <= '0;
			prev_filtered_deriv_q <= '0;
			running_total_q       <= '0;
			sat_side_q            <= gspid_pkg::SIDE_NONE;
			result_valid_q        <= 1'b0;
		end else begin
			if (fire_fin) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			if (fire_fin) begin
				prev_error_q <= e_q;
				case (loop_mode_q)
					gspid_pkg::MODE_POS: error_sum_q <= es_next_q;
					gspid_pkg::MODE_INC: begin
						running_total_q       <= rt_new_q;
						prev_filtered_deriv_q <= pfd_new_c;
					end
					gspid_pkg::MODE_VAR: begin
						error_sum_q           <= es_next_q;
						prev_filtered_deriv_q <= pfd_new_c;
						sat_side_q            <= res_c.clamp_side;
					end
					default: ;
				endcase
			end
		end
	end

endmodule
